// ===== rtl/button_debounce_repeat_macros.svh =====
// Assertion macros for the button debounce block
`ifndef BUTTON_DEBOUNCE_REPEAT_MACROS_SVH
`define BUTTON_DEBOUNCE_REPEAT_MACROS_SVH

`ifndef SYNTH
`define BDR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define BDR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BDR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define BDR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/bdr_pkg.sv =====
// Shared types and constants for the button debounce block
package bdr_pkg;

	localparam int TIME_W    = 32;
	localparam int DLY_W     = 16;
	localparam int MASK_W    = 8;
	localparam int BTN_IDX_W = 3;
	localparam int KIND_W    = 2;
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;

	localparam logic [MASK_W-1:0] MASK_ALL = 8'hFF;

	// button phases
	localparam logic [1:0] PH_UP       = 2'd0;
	localparam logic [1:0] PH_DEB_DOWN = 2'd1;
	localparam logic [1:0] PH_DOWN     = 2'd2;
	localparam logic [1:0] PH_DEB_UP   = 2'd3;

	// event codes
	localparam logic [KIND_W-1:0] EV_NONE    = 2'd0;
	localparam logic [KIND_W-1:0] EV_PRESS   = 2'd1;
	localparam logic [KIND_W-1:0] EV_REPEAT  = 2'd2;
	localparam logic [KIND_W-1:0] EV_RELEASE = 2'd3;

	// register indexes
	localparam logic [1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [1:0] REG_HOLD     = 2'd1;
	localparam logic [1:0] REG_PERIOD   = 2'd2;

	localparam logic [DLY_W-1:0] DEBOUNCE_RST = 16'd20;
	localparam logic [DLY_W-1:0] HOLD_RST     = 16'd500;
	localparam logic [DLY_W-1:0] PERIOD_RST   = 16'd100;

	typedef struct packed {
		logic [DLY_W-1:0] debounce_time;
		logic [DLY_W-1:0] hold_time;
		logic [DLY_W-1:0] repeat_period;
	} cfg_t;

	typedef struct packed {
		logic load;      // take the poll word, restart the scan
		logic scan;      // evaluate and update the current button
		logic out_now;   // load output register from this cycle's result
		logic save;      // park this cycle's result
		logic out_saved; // load output register from the parked result
	} cmd_t;

	typedef struct packed {
		logic hit;       // current button produced an event
		logic last;      // current button is the last one
		logic out_free;  // output register can take a word this cycle
	} status_t;

	typedef struct packed {
		logic [KIND_W-1:0]    event_kind;
		logic [BTN_IDX_W-1:0] button_index;
	} result_t;

endpackage

// ===== rtl/bdr_if.sv =====
// Handshake interfaces for poll words and event words
interface bdr_poll_if;
	logic                          valid;
	logic                          ready;
	logic [bdr_pkg::TIME_W-1:0]    now_ms;
	logic [bdr_pkg::MASK_W-1:0]    pressed_mask;

	modport source (output valid, output now_ms, output pressed_mask, input ready);
	modport sink (input valid, input now_ms, input pressed_mask, output ready);
endinterface

interface bdr_event_if;
	logic                          valid;
	logic                          ready;
	logic [bdr_pkg::KIND_W-1:0]    event_kind;
	logic [bdr_pkg::BTN_IDX_W-1:0] button_index;

	modport source (output valid, output event_kind, output button_index, input ready);
	modport sink (input valid, input event_kind, input button_index, output ready);
endinterface

// ===== rtl/bdr_cfg.sv =====
// APB register file for the debounce, hold and repeat delays
module bdr_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bdr_pkg::ADDR_W-1:0]   paddr,
	input  logic [bdr_pkg::DATA_W-1:0]   pwdata,
	output logic [bdr_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output bdr_pkg::cfg_t                cfg
);
	import bdr_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time <= DEBOUNCE_RST;
			cfg_q.hold_time     <= HOLD_RST;
			cfg_q.repeat_period <= PERIOD_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_DEBOUNCE: cfg_q.debounce_time <= pwdata[DLY_W-1:0];
				REG_HOLD:     cfg_q.hold_time     <= pwdata[DLY_W-1:0];
				REG_PERIOD:   cfg_q.repeat_period <= pwdata[DLY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_DEBOUNCE: prdata = DATA_W'(cfg_q.debounce_time);
			REG_HOLD:     prdata = DATA_W'(cfg_q.hold_time);
			REG_PERIOD:   prdata = DATA_W'(cfg_q.repeat_period);
			default:      prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/bdr_ctrl.sv =====
// Scan sequencer: accepts a poll, steps through buttons, hands off the event word
module bdr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               poll_valid,
	output logic               poll_ready,
	input  bdr_pkg::status_t   status,
	output bdr_pkg::cmd_t      cmd
);
	import bdr_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign poll_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (poll_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.hit || status.last) begin
					if (status.out_free) begin
						cmd.out_now = 1'b1;
						state_d     = ST_IDLE;
					end else begin
						cmd.save = 1'b1;
						state_d  = ST_HOLD;
					end
				end
			end
			ST_HOLD: begin
				if (status.out_free) begin
					cmd.out_saved = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/bdr_dp.sv =====
// Per-button state store, elapsed-time compare and output register
module bdr_dp #(
	parameter int BUTTONS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bdr_pkg::cfg_t                 cfg,
	input  bdr_pkg::cmd_t                 cmd,
	output bdr_pkg::status_t              status,
	input  logic [bdr_pkg::TIME_W-1:0]    now_ms,
	input  logic [bdr_pkg::MASK_W-1:0]    pressed_mask,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bdr_pkg::KIND_W-1:0]    event_kind,
	output logic [bdr_pkg::BTN_IDX_W-1:0] button_index
);
	import bdr_pkg::*;

	localparam int IW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

	// poll word under scan
	logic [TIME_W-1:0]  now_q;
	logic [BUTTONS-1:0] mask_q;
	logic [IW-1:0]      idx_q;

	// per-button state; ref_q is the press time, then the last repeat time
	logic [1:0]        phase_q   [BUTTONS];
	logic              started_q [BUTTONS];
	logic [TIME_W-1:0] edge_q    [BUTTONS];
	logic [TIME_W-1:0] ref_q     [BUTTONS];

	logic [1:0]        ph;
	logic              down;
	logic [TIME_W-1:0] el_edge;
	logic [TIME_W-1:0] el_ref;
	logic [TIME_W-1:0] deb_lim;
	logic [TIME_W-1:0] rep_lim;
	logic [1:0]        ph_d;
	logic              wr_edge;
	logic              wr_ref;
	logic              set_started;
	logic              clr_started;
	logic [KIND_W-1:0] kind_c;
	result_t           res_c;
	result_t           res_q;
	result_t           out_q;
	logic              out_valid_q;

	assign ph      = phase_q[idx_q];
	assign down    = mask_q[idx_q];
	assign el_edge = now_q - edge_q[idx_q];
	assign el_ref  = now_q - ref_q[idx_q];
	assign deb_lim = TIME_W'(cfg.debounce_time);
	assign rep_lim = started_q[idx_q] ? TIME_W'(cfg.repeat_period) : TIME_W'(cfg.hold_time);

	always_comb begin
		ph_d        = ph;
		wr_edge     = 1'b0;
		wr_ref      = 1'b0;
		set_started = 1'b0;
		clr_started = 1'b0;
		kind_c      = EV_NONE;
		unique case (ph)
			PH_UP: begin
				if (down) begin
					ph_d    = PH_DEB_DOWN;
					wr_edge = 1'b1;
				end
			end
			PH_DEB_DOWN: begin
				if (!down) begin
					ph_d = PH_UP;
				end else if (el_edge >= deb_lim) begin
					ph_d        = PH_DOWN;
					wr_ref      = 1'b1;
					clr_started = 1'b1;
					kind_c      = EV_PRESS;
				end
			end
			PH_DOWN: begin
				if (!down) begin
					ph_d    = PH_DEB_UP;
					wr_edge = 1'b1;
				end else if (el_ref >= rep_lim) begin
					set_started = 1'b1;
					wr_ref      = 1'b1;
					kind_c      = EV_REPEAT;
				end
			end
			PH_DEB_UP: begin
				// bounce back to down keeps the hold and repeat state
				if (down) begin
					ph_d = PH_DOWN;
				end else if (el_edge >= deb_lim) begin
					ph_d   = PH_UP;
					kind_c = EV_RELEASE;
				end
			end
			default: ph_d = PH_UP;
		endcase
	end

	assign res_c.event_kind   = kind_c;
	assign res_c.button_index = (kind_c != EV_NONE) ? BTN_IDX_W'(idx_q) : '0;

	assign status.hit      = (kind_c != EV_NONE);
	assign status.last     = (idx_q == IW'(BUTTONS - 1));
	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q  <= now_ms;
			mask_q <= pressed_mask[BUTTONS-1:0] & MASK_ALL[BUTTONS-1:0];
		end
		if (cmd.scan && wr_edge) begin
			edge_q[idx_q] <= now_q;
		end
		if (cmd.scan && wr_ref) begin
			ref_q[idx_q] <= now_q;
		end
		if (cmd.save) begin
			res_q <= res_c;
		end
		if (cmd.out_now) begin
			out_q <= res_c;
		end else if (cmd.out_saved) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			for (int b = 0; b < BUTTONS; b++) begin
				phase_q[b]   <= PH_UP;
				started_q[b] <= 1'b0;
			end
		end else begin
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.scan && !status.last) begin
				idx_q <= idx_q + IW'(1);
			end
			if (cmd.scan) begin
				phase_q[idx_q] <= ph_d;
				if (set_started) begin
					started_q[idx_q] <= 1'b1;
				end else if (clr_started) begin
					started_q[idx_q] <= 1'b0;
				end
			end
			if (cmd.out_now || cmd.out_saved) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign event_kind   = out_q.event_kind;
	assign button_index = out_q.button_index;

endmodule

// ===== rtl/button_debounce_repeat.sv =====
// Button debouncer with auto-repeat, one event word per poll word.
// The poll is taken first, then the buttons are scanned in order (up to BUTTONS) until one produces an event,
// with the event word registered at the output when the scan ends, or parked until the output is free.
// The scan visits one button per cycle; a new poll is not taken until the event word is in the output register.
// A new poll is taken while the previous event word waits at the output.
// arst_n clears all buttons to up and restores delays to 20, 500 and 100 ms.
`include "button_debounce_repeat_macros.svh"

module button_debounce_repeat #(
	parameter int BUTTONS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	bdr_poll_if.sink                   poll,
	bdr_event_if.source                result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bdr_pkg::ADDR_W-1:0] paddr,
	input  logic [bdr_pkg::DATA_W-1:0] pwdata,
	output logic [bdr_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import bdr_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	bdr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bdr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.poll_valid (poll.valid),
		.poll_ready (poll.ready),
		.status     (status),
		.cmd        (cmd)
	);

	bdr_dp #(
		.BUTTONS (BUTTONS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.status       (status),
		.now_ms       (poll.now_ms),
		.pressed_mask (poll.pressed_mask),
		.out_valid    (result.valid),
		.out_ready    (result.ready),
		.event_kind   (result.event_kind),
		.button_index (result.button_index)
	);

	`BDR_ASSERT_NEXT(a_busy_after_poll, clk, arst_n, poll.valid && poll.ready, !poll.ready, "poll taken while a scan is running")
	`BDR_ASSERT_NEXT(a_word_after_load, clk, arst_n, cmd.out_now || cmd.out_saved, result.valid, "event word not presented after load")
	`BDR_ASSERT_SAME(a_none_index_zero, clk, arst_n, result.valid && (result.event_kind == EV_NONE), result.button_index == '0, "empty event word carries a button index")
	`BDR_ASSERT_SAME(a_cmd_exclusive, clk, arst_n, 1'b1, $onehot0({cmd.load, cmd.save, cmd.out_now, cmd.out_saved}), "conflicting sequencer commands")

endmodule
